[rtl/spf_pkg.sv]
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types and constants of the smallest-prime-factor factorizer.
// ----------------------------------------------------------------------------
package spf_pkg;

    localparam int DATA_W     = 16;
    localparam int VALUE_SPAN = 65536;
    localparam int DIV_STEPS  = DATA_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // controller to datapath
    typedef struct packed {
        logic fill_step;
        logic load_n;
        logic set_p;
        logic div_start;
        logic div_step;
        logic emit;
        logic emit_last;
        logic emit_zero;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic fill_last;
        logic in_trivial;
        logic f_eq_p;
        logic div_last;
        logic n_is_one;
        logic out_free;
    } t_dp_sts;

endpackage

[rtl/spf_ram.sv]
// ----------------------------------------------------------------------------
// spf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/spf_datapath.sv]
// ----------------------------------------------------------------------------
// spf_datapath
// Factor table with its sieve counters, the working number, the current
// prime, a restoring divider and the result register.
// ----------------------------------------------------------------------------
module spf_datapath #(
    parameter int DEPTH = 65536
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  spf_pkg::t_dp_cmd           i_cmd,
    output spf_pkg::t_dp_sts           o_sts,
    input  logic [spf_pkg::DATA_W-1:0] i_value,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [spf_pkg::DATA_W-1:0] o_prime,
    output logic                       o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW:0] DEPTH_A = (AW+1)'(DEPTH);
    localparam logic [AW-1:0] TOP_IDX = AW'(DEPTH - 1);
    localparam logic [spf_pkg::DATA_W:0] DEPTH_V = (spf_pkg::DATA_W+1)'(DEPTH);

    // sieve counters: outer runs down from the top, inner walks its multiples
    logic [AW-1:0] r_si, n_si;
    logic [AW-1:0] r_sj, n_sj;
    logic [AW:0]   sum_j;
    logic          wrap_j;

    logic [spf_pkg::DATA_W-1:0] r_n, n_n;
    logic [spf_pkg::DATA_W-1:0] r_p, n_p;
    logic [spf_pkg::DATA_W-1:0] r_q, n_q;
    logic [spf_pkg::DATA_W-1:0] r_r, n_r;
    logic [spf_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [spf_pkg::DATA_W:0]   trial;
    logic [spf_pkg::DATA_W-1:0] q_step;
    logic [spf_pkg::DATA_W-1:0] r_step;

    logic                       r_ovalid, n_ovalid;
    logic [spf_pkg::DATA_W-1:0] r_prime, n_prime;
    logic                       r_last, n_last;

    logic [spf_pkg::DATA_W-1:0] rd_data;

    spf_ram #(
        .WIDTH (spf_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.fill_step),
        .i_waddr (r_sj),
        .i_wdata (spf_pkg::DATA_W'(r_si)),
        .i_raddr (r_n[AW-1:0]),
        .o_rdata (rd_data)
    );

    assign sum_j  = {1'b0, r_sj} + {1'b0, r_si};
    assign wrap_j = (sum_j >= DEPTH_A);

    // one restoring division step
    always_comb begin
        trial = {r_r, r_q[spf_pkg::DATA_W-1]};
        if (trial >= {1'b0, r_p}) begin
            r_step = spf_pkg::DATA_W'(trial - {1'b0, r_p});
            q_step = {r_q[spf_pkg::DATA_W-2:0], 1'b1};
        end else begin
            r_step = trial[spf_pkg::DATA_W-1:0];
            q_step = {r_q[spf_pkg::DATA_W-2:0], 1'b0};
        end
    end

    always_comb begin
        n_si     = r_si;
        n_sj     = r_sj;
        n_n      = r_n;
        n_p      = r_p;
        n_q      = r_q;
        n_r      = r_r;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid;
        n_prime  = r_prime;
        n_last   = r_last;

        if (i_cmd.fill_step) begin
            if (wrap_j) begin
                n_si = r_si - 1'b1;
                n_sj = r_si - 1'b1;
            end else begin
                n_sj = sum_j[AW-1:0];
            end
        end
        if (i_cmd.load_n) begin
            n_n = i_value;
        end
        if (i_cmd.set_p) begin
            n_p = rd_data;
        end
        if (i_cmd.div_start) begin
            n_q   = r_n;
            n_r   = '0;
            n_cnt = '0;
        end
        if (i_cmd.div_step) begin
            n_q   = q_step;
            n_r   = r_step;
            n_cnt = r_cnt + 1'b1;
            if (o_sts.div_last) begin
                n_n = q_step;
            end
        end

        if (i_cmd.emit) begin
            n_ovalid = 1'b1;
            n_prime  = i_cmd.emit_zero ? '0 : r_p;
            n_last   = i_cmd.emit_last;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_si     <= TOP_IDX;
            r_sj     <= TOP_IDX;
            r_ovalid <= 1'b0;
        end else begin
            r_si     <= n_si;
            r_sj     <= n_sj;
            r_ovalid <= n_ovalid;
        end
        r_n     <= n_n;
        r_p     <= n_p;
        r_q     <= n_q;
        r_r     <= n_r;
        r_cnt   <= n_cnt;
        r_prime <= n_prime;
        r_last  <= n_last;
    end

    assign o_sts.fill_last  = wrap_j && (r_si == AW'(2));
    assign o_sts.in_trivial = (i_value < spf_pkg::DATA_W'(2))
                            || ({1'b0, i_value} >= DEPTH_V);
    assign o_sts.f_eq_p     = (rd_data == r_p);
    assign o_sts.div_last   = (r_cnt == spf_pkg::DIV_CNT_W'(spf_pkg::DIV_STEPS - 1));
    assign o_sts.n_is_one   = (r_n == spf_pkg::DATA_W'(1));
    assign o_sts.out_free   = !r_ovalid || i_out_ready;

    assign o_out_valid = r_ovalid;
    assign o_prime     = r_prime;
    assign o_last      = r_last;

endmodule

[rtl/spf_ctrl.sv]
// ----------------------------------------------------------------------------
// spf_ctrl
// Sequencer: runs the table fill, then walks each item through table reads
// and divisions and issues one result per distinct prime, zero when trivial.
// ----------------------------------------------------------------------------
module spf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  spf_pkg::t_dp_sts i_sts,
    output spf_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] S_FILL = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_LOOK = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_NEXT = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_have, n_have;

    assign o_in_ready = (r_state == S_IDLE) && i_sts.out_free;

    always_comb begin
        n_state = r_state;
        n_have  = r_have;
        o_cmd   = '0;

        unique case (r_state)
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_sts.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    if (i_sts.in_trivial) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_last = 1'b1;
                        o_cmd.emit_zero = 1'b1;
                    end else begin
                        o_cmd.load_n = 1'b1;
                        n_have       = 1'b0;
                        n_state      = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_LOOK;
            end
            S_LOOK: begin
                if (!r_have) begin
                    o_cmd.set_p     = 1'b1;
                    o_cmd.div_start = 1'b1;
                    n_have          = 1'b1;
                    n_state         = S_DIV;
                end else if (i_sts.f_eq_p) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else if (i_sts.out_free) begin
                    // new prime: the finished one goes out first
                    o_cmd.emit      = 1'b1;
                    o_cmd.set_p     = 1'b1;
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (!i_sts.n_is_one) begin
                    n_state = S_READ;
                end else if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
            r_have  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_have  <= n_have;
        end
    end

endmodule

[rtl/spf_sieve_prime_factorizer.sv]
// ----------------------------------------------------------------------------
// spf_sieve_prime_factorizer
// Smallest-prime-factor table built by a sieve after reset, then factoring
// of one number per item into its distinct primes in ascending order.
// ----------------------------------------------------------------------------
// Reset (synchronous, active low) starts the table fill, one write a cycle
// over a table of min(LIMIT, 65536) entries; no item is taken before it ends.
// Per item: taken in the idle state, then each prime factor counted with
// multiplicity goes through read, look-up, 16-step restoring divide and
// check; values below 2 or past the table give one zero result. One item
// at a time; a result held at the output stalls the sequencer and the input.
module spf_sieve_prime_factorizer #(
    parameter int LIMIT = 65536
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [spf_pkg::DATA_W-1:0] i_value,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [spf_pkg::DATA_W-1:0] o_prime,
    output logic                       o_last
);

    // entries at or above the 16-bit value range are never read
    localparam int DEPTH = (LIMIT > spf_pkg::VALUE_SPAN) ? spf_pkg::VALUE_SPAN : LIMIT;

    spf_pkg::t_dp_cmd cmd;
    spf_pkg::t_dp_sts sts;

    spf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    spf_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_value     (i_value),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_prime     (o_prime),
        .o_last      (o_last)
    );

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Checks the sieve factorizer: waits out the table fill after reset, then
// sends numbers and compares every emitted prime and last flag against a
// factorization computed here from a locally built smallest-factor table.
// Both handshakes idle at random, with calm stretches of back-to-back items.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DATA_W       = spf_pkg::DATA_W;
    localparam int          VALUE_SPAN   = spf_pkg::VALUE_SPAN;
    localparam int          CYCLE_LIMIT  = 4000000;
    localparam int          RESET_CYCLES = 10;
    localparam int          DRAIN_CYCLES = 400;
    localparam int unsigned MAX_IDLE     = 18;
    localparam int          RANDOM_ITEMS = 190;

    typedef struct packed {
        logic [DATA_W-1:0] prime;
        logic              last;
    } t_factor;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic [DATA_W-1:0] i_value     = '0;
    logic              i_out_ready = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic [DATA_W-1:0] o_prime;
    logic              o_last;

    spf_sieve_prime_factorizer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_prime     (o_prime),
        .o_last      (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    int unsigned       smallest_factor [VALUE_SPAN];
    int unsigned       small_primes [8] = '{2, 3, 5, 7, 11, 13, 17, 19};
    int unsigned       directed_values [22] = '{
        0, 1, 2, 3, 4, 9, 12, 49, 210, 2310, 30030, 39270, 16384, 32768,
        59049, 65025, 65521, 65534, 65535, 65533, 43690, 21845
    };

    logic [DATA_W-1:0] value_queue [$];
    t_factor           expected_factors [$];

    int unsigned       items_total       = 0;
    int unsigned       items_sent        = 0;
    int unsigned       items_done        = 0;
    int unsigned       results_seen      = 0;
    int unsigned       below_two         = 0;
    int unsigned       primes_seen       = 0;
    int unsigned       six_factor_values = 0;
    int unsigned       error_count       = 0;
    int unsigned       cycle_count       = 0;
    int unsigned       fill_cycles       = 0;
    int unsigned       send_wait         = 0;
    int unsigned       hold_cnt          = 0;
    logic              in_fire           = 1'b0;
    logic              out_fire          = 1'b0;
    logic              table_seen        = 1'b0;

    // calm windows give runs of items with no idling at all
    function automatic int unsigned draw_idle(input int unsigned count);
        if ((count / 24) % 4 == 3) begin
            return 0;
        end
        return $urandom_range(0, MAX_IDLE);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // distinct primes of value in ascending order, last flag on the final one
    function automatic void push_factors(input logic [DATA_W-1:0] value);
        int unsigned n;
        int unsigned p;
        int unsigned cnt;
        t_factor     f;
        n   = 32'(value);
        cnt = 0;
        if (n < 2) begin
            f.prime = '0;
            f.last  = 1'b1;
            expected_factors.insert(expected_factors.size(), f);
            return;
        end
        while (n != 1) begin
            p = smallest_factor[n];
            while (n >= 2 && smallest_factor[n] == p) begin
                n = n / p;
            end
            f.prime = p[DATA_W-1:0];
            f.last  = (n == 1);
            expected_factors.insert(expected_factors.size(), f);
            cnt++;
        end
        if (cnt == 6) begin
            six_factor_values++;
        end
    endfunction

    // item driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_wait  <= 0;
        end else if (!(i_in_valid && !in_fire)) begin
            if (send_wait != 0) begin
                send_wait  <= send_wait - 1;
                i_in_valid <= 1'b0;
            end else if (value_queue.size() != 0) begin
                i_value    <= value_queue.pop_front();
                i_in_valid <= 1'b1;
                send_wait  <= draw_idle(items_sent);
                items_sent <= items_sent + 1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver stalls
    always @(negedge i_clk) begin : ready_drive
        int unsigned stall;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_cnt    <= 0;
        end else if (out_fire) begin
            stall = draw_idle(results_seen);
            if (stall == 0) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b0;
                hold_cnt    <= stall - 1;
            end
        end else if (hold_cnt != 0) begin
            hold_cnt    <= hold_cnt - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // sampling: predict on accepted items, check accepted results
    always @(posedge i_clk) begin : monitor
        t_factor want;
        cycle_count++;
        in_fire  = i_rst_n && i_in_valid && o_in_ready;
        out_fire = i_rst_n && o_out_valid && i_out_ready;
        if (i_rst_n && o_in_ready && !table_seen) begin
            table_seen  = 1'b1;
            fill_cycles = cycle_count;
        end
        if (in_fire) begin
            push_factors(i_value);
            items_done++;
            if (i_value < 2) begin
                below_two++;
            end else if (smallest_factor[i_value] == 32'(i_value)) begin
                primes_seen++;
            end
        end
        if (out_fire) begin
            results_seen++;
            if (expected_factors.size() == 0) begin
                report_mismatch($sformatf("unexpected result prime=%0d last=%0b",
                                          o_prime, o_last));
            end else begin
                want = expected_factors.pop_front();
                if (o_prime !== want.prime) begin
                    report_mismatch($sformatf("prime got %0d want %0d",
                                              o_prime, want.prime));
                end
                if (o_last !== want.last) begin
                    report_mismatch($sformatf("last got %0b want %0b (prime %0d)",
                                              o_last, want.last, want.prime));
                end
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d items taken, %0d results pending",
                     cycle_count, items_done, items_total, expected_factors.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned v;
        int unsigned p;
        for (int i = 0; i < VALUE_SPAN; i++) begin
            smallest_factor[i] = 0;
        end
        for (int i = 2; i < VALUE_SPAN; i++) begin
            if (smallest_factor[i] == 0) begin
                for (int m = i; m < VALUE_SPAN; m += i) begin
                    if (smallest_factor[m] == 0) begin
                        smallest_factor[m] = i;
                    end
                end
            end
        end

        foreach (directed_values[k]) begin
            value_queue.insert(value_queue.size(), directed_values[k][DATA_W-1:0]);
        end

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: v = $urandom_range(0, VALUE_SPAN - 1);
                3: v = $urandom_range(0, 40);
                4, 5, 6: begin
                    // smooth numbers give many distinct factors
                    v = 1;
                    repeat (12) begin
                        p = small_primes[$urandom_range(0, 7)];
                        if (v * p < VALUE_SPAN) begin
                            v = v * p;
                        end
                    end
                end
                7: begin
                    v = $urandom_range(2, VALUE_SPAN - 1);
                    while (smallest_factor[v] != v) begin
                        v--;
                    end
                end
                8: begin
                    if ($urandom_range(0, 1) == 0) begin
                        v = 1 << $urandom_range(0, 15);
                    end else begin
                        v = 1;
                        repeat ($urandom_range(0, 10)) v = v * 3;
                    end
                end
                default: v = VALUE_SPAN - 1 - $urandom_range(0, 63);
            endcase
            value_queue.insert(value_queue.size(), v[DATA_W-1:0]);
        end
        items_total = value_queue.size();

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (items_done != items_total) @(posedge i_clk);
        while (expected_factors.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d values: %0d below two, %0d primes, %0d with six factors",
                 items_done, below_two, primes_seen, six_factor_values);
        $display("checked %0d factors; table ready after %0d cycles; %0d mismatches",
                 results_seen, fill_cycles, error_count);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
